// ===== design/avp_pkg.sv =====
// ----------------------------------------------------------------------------
// avp_pkg: shared types, codes and fp16 helpers
// Controller/datapath command and status records, register indexes and the
// fp16 rounding and addition functions used by the pooling datapath.
// ----------------------------------------------------------------------------
package avp_pkg;

  localparam logic [2:0] CFG_IN_HEIGHT     = 3'd0;
  localparam logic [2:0] CFG_IN_WIDTH      = 3'd1;
  localparam logic [2:0] CFG_OUT_HEIGHT    = 3'd2;
  localparam logic [2:0] CFG_OUT_WIDTH     = 3'd3;
  localparam logic [2:0] CFG_KERNEL_HEIGHT = 3'd4;
  localparam logic [2:0] CFG_KERNEL_WIDTH  = 3'd5;
  localparam logic [2:0] CFG_STRIDE_HEIGHT = 3'd6;
  localparam logic [2:0] CFG_STRIDE_WIDTH  = 3'd7;

  localparam logic [6:0] OUT_MAX    = 7'd64;
  localparam logic [4:0] STRIDE_MAX = 5'd16;
  localparam int         POS_W      = 12;
  localparam int         CNT_W      = 13;

  localparam logic [15:0] FP16_QNAN = 16'h7E00;
  localparam logic [14:0] FP16_INF  = 15'h7C00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_BASE,
    ST_SUM,
    ST_DRAIN,
    ST_DIV,
    ST_DIVW,
    ST_OUT
  } avp_state_t;

  typedef struct packed {
    logic load;
    logic req;
    logic win;
    logic base;
    logic issue;
    logic div_start;
    logic out_load;
  } avp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_issue;
    logic div_done;
    logic out_free;
  } avp_sts_t;

  // m: hidden bit at [13], guard at [2], sticky in [1:0]; e >= 1
  function automatic logic [15:0] fp16_round(input logic s, input logic [5:0] e,
                                             input logic [13:0] m);
    logic [10:0] mt;
    logic        inc;
    logic [15:0] sum;
    logic [15:0] res;
    mt  = m[13:3];
    inc = m[2] & ((|m[1:0]) | mt[0]);
    sum = {1'b0, 5'(e - 6'd1), 10'd0} + 16'(mt) + 16'(inc);
    if (sum >= 16'h7C00) begin
      res = {s, FP16_INF};
    end else begin
      res = {s, sum[14:0]};
    end
    return res;
  endfunction

  function automatic logic [15:0] fp16_add(input logic [15:0] a, input logic [15:0] b);
    logic        a_nan, b_nan, a_inf, b_inf, sub, stk;
    logic [15:0] big, sml, res;
    logic [4:0]  eb, es, d;
    logic [13:0] mb, ms, al, m;
    logic [14:0] s15;
    logic [5:0]  e, lim;
    logic [3:0]  lz;
    a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
    b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
    a_inf = (a[14:0] == FP16_INF);
    b_inf = (b[14:0] == FP16_INF);
    res = 16'd0;
    if (a_nan || b_nan) begin
      res = FP16_QNAN;
    end else if (a_inf && b_inf) begin
      res = (a[15] != b[15]) ? FP16_QNAN : a;
    end else if (a_inf) begin
      res = a;
    end else if (b_inf) begin
      res = b;
    end else begin
      if (a[14:0] >= b[14:0]) begin
        big = a;
        sml = b;
      end else begin
        big = b;
        sml = a;
      end
      eb = (big[14:10] == 5'd0) ? 5'd1 : big[14:10];
      es = (sml[14:10] == 5'd0) ? 5'd1 : sml[14:10];
      mb = {big[14:10] != 5'd0, big[9:0], 3'b000};
      ms = {sml[14:10] != 5'd0, sml[9:0], 3'b000};
      d  = eb - es;
      if (d >= 5'd14) begin
        al  = 14'd0;
        stk = |ms;
      end else begin
        al  = ms >> d;
        stk = |(ms & ~(14'h3FFF << d));
      end
      al[0] = al[0] | stk;
      sub = big[15] ^ sml[15];
      s15 = sub ? ({1'b0, mb} - {1'b0, al}) : ({1'b0, mb} + {1'b0, al});
      e = {1'b0, eb};
      if (s15 == 15'd0) begin
        res = {big[15] & sml[15], 15'd0};
      end else if (s15[14]) begin
        m   = {s15[14:2], s15[1] | s15[0]};
        res = fp16_round(big[15], e + 6'd1, m);
      end else begin
        m  = s15[13:0];
        lz = 4'd0;
        for (int i = 0; i < 14; i++) begin
          if (m[i]) lz = 4'(13 - i);
        end
        lim = e - 6'd1;
        if (6'(lz) < lim) begin
          m = m << lz;
          e = e - 6'(lz);
        end else begin
          m = m << lim;
          e = 6'd1;
        end
        res = fp16_round(big[15], e, m);
      end
    end
    return res;
  endfunction

endpackage

// ===== design/avp_in_if.sv =====
// ----------------------------------------------------------------------------
// avp_in_if: input item channel
// Carries a load/request mode bit and an fp16 pixel.
// ----------------------------------------------------------------------------
interface avp_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] pixel;

  modport source (output valid, output mode, output pixel, input ready);
  modport sink (input valid, input mode, input pixel, output ready);
endinterface

// ===== design/avp_out_if.sv =====
// ----------------------------------------------------------------------------
// avp_out_if: result channel
// Carries the fp16 window average and the end-of-plane flag.
// ----------------------------------------------------------------------------
interface avp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] average;
  logic        last_of_plane;

  modport source (output valid, output average, output last_of_plane, input ready);
  modport sink (input valid, input average, input last_of_plane, output ready);
endinterface

// ===== design/avp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// avp_cfg_if: configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface avp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [6:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/avp_ram.sv =====
// ----------------------------------------------------------------------------
// avp_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module avp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/avp_div.sv =====
// ----------------------------------------------------------------------------
// avp_div: iterative fp16 divide by pixel count
// Converts the count to fp16, then restoring division one quotient bit per
// cycle, then round to nearest even with subnormal handling.
// ----------------------------------------------------------------------------
module avp_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [15:0]             num,
  input  logic [avp_pkg::CNT_W-1:0] cnt,
  output logic                    done,
  output logic [15:0]             quo
);

  import avp_pkg::*;

  logic              busy;
  logic [3:0]        iter;
  logic              sgn;
  logic signed [6:0] qexp;
  logic [11:0]       rem;
  logic [10:0]       md;
  logic [13:0]       q;

  logic              spec;
  logic [15:0]       spec_val;
  logic [10:0]       ma, md_n;
  logic signed [6:0] ea, ed, e_n;
  logic [11:0]       rem_n;
  logic [3:0]        pn, pc;
  logic [CNT_W-1:0]  t, rb, halfv;
  logic              up;
  logic signed [6:0] be;
  logic [6:0]        shr;
  logic [13:0]       m14, mm;
  logic [15:0]       quo_n;

  // unpack numerator, convert count, line up the mantissas
  always_comb begin
    spec     = 1'b0;
    spec_val = 16'd0;
    pn       = 4'd0;
    pc       = 4'd0;
    ma       = 11'd0;
    ea       = 7'sd0;
    md_n     = 11'd1024;
    ed       = 7'sd0;
    t        = '0;
    rb       = '0;
    halfv    = '0;
    up       = 1'b0;
    if ((num[14:10] == 5'h1F) && (num[9:0] != 10'd0)) begin
      spec     = 1'b1;
      spec_val = FP16_QNAN;
    end else if (num[14:0] == FP16_INF || num[14:0] == 15'd0) begin
      spec     = 1'b1;
      spec_val = num;
    end
    if (num[14:10] != 5'd0) begin
      ma = {1'b1, num[9:0]};
      ea = $signed(7'(num[14:10])) - 7'sd15;
    end else begin
      for (int i = 0; i < 10; i++) begin
        if (num[i]) pn = 4'(i);
      end
      ma = 11'(num[9:0]) << (4'd10 - pn);
      ea = $signed(7'(pn)) - 7'sd24;
    end
    for (int i = 0; i < CNT_W; i++) begin
      if (cnt[i]) pc = 4'(i);
    end
    if (pc <= 4'd10) begin
      md_n = 11'(cnt << (4'd10 - pc));
      ed   = $signed(7'(pc));
    end else begin
      t     = cnt >> (pc - 4'd10);
      rb    = cnt & ~({CNT_W{1'b1}} << (pc - 4'd10));
      halfv = CNT_W'(1) << (pc - 4'd11);
      up    = (rb > halfv) || ((rb == halfv) && t[0]);
      t     = t + CNT_W'(up);
      if (t == CNT_W'(2048)) begin
        md_n = 11'd1024;
        ed   = $signed(7'(pc)) + 7'sd1;
      end else begin
        md_n = t[10:0];
        ed   = $signed(7'(pc));
      end
    end
    if (ma >= md_n) begin
      rem_n = {1'b0, ma};
      e_n   = ea - ed;
    end else begin
      rem_n = {ma, 1'b0};
      e_n   = ea - ed - 7'sd1;
    end
  end

  // final rounding
  always_comb begin
    be  = qexp + 7'sd15;
    m14 = {q[13:1], q[0] | (rem != 12'd0)};
    shr = 7'(7'sd1 - be);
    mm  = m14;
    if (be >= 7'sd1) begin
      quo_n = fp16_round(sgn, 6'(be), m14);
    end else begin
      if (shr >= 7'd14) begin
        mm = {13'd0, |m14};
      end else begin
        mm    = m14 >> shr;
        mm[0] = mm[0] | (|(m14 & ~(14'h3FFF << shr)));
      end
      quo_n = fp16_round(sgn, 6'd1, mm);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (spec) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          iter <= 4'd14;
        end
      end else if (busy) begin
        if (iter != 4'd0) begin
          iter <= iter - 4'd1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sgn  <= num[15];
      qexp <= e_n;
      rem  <= rem_n;
      md   <= md_n;
      q    <= 14'd0;
      if (spec) quo <= spec_val;
    end else if (busy) begin
      if (iter != 4'd0) begin
        if (rem >= {1'b0, md}) begin
          q   <= {q[12:0], 1'b1};
          rem <= 12'((rem - {1'b0, md}) << 1);
        end else begin
          q   <= {q[12:0], 1'b0};
          rem <= rem << 1;
        end
      end else begin
        quo <= quo_n;
      end
    end
  end

endmodule

// ===== design/avp_ctrl.sv =====
// ----------------------------------------------------------------------------
// avp_ctrl: pooling sequencer
// Accepts loads and requests, then steps a request through window setup,
// pixel summation, division and result hand-off.
// ----------------------------------------------------------------------------
module avp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  avp_pkg::avp_sts_t sts,
  output avp_pkg::avp_cmd_t cmd
);

  import avp_pkg::*;

  avp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            cmd.req    = 1'b1;
            state_next = ST_WIN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_WIN: begin
        cmd.win    = 1'b1;
        state_next = ST_BASE;
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = sts.empty ? ST_OUT : ST_SUM;
      end
      ST_SUM: begin
        cmd.issue = 1'b1;
        if (sts.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/avp_dp.sv =====
// ----------------------------------------------------------------------------
// avp_dp: pooling datapath
// Configuration registers, plane RAM, load and output counters, window
// clipping, fp16 accumulator, divider and output register.
// ----------------------------------------------------------------------------
module avp_dp #(
  parameter int MAX_IN_DIM = 64,
  parameter int MAX_KERNEL = 16,
  parameter int PAD_H      = 0,
  parameter int PAD_W      = 0
) (
  input  logic              clk,
  input  logic              rst,
  avp_in_if.sink            in_item,
  avp_out_if.source         out_item,
  avp_cfg_if.sink           cfg,
  input  avp_pkg::avp_cmd_t cmd,
  output avp_pkg::avp_sts_t sts
);

  import avp_pkg::*;

  localparam int DEPTH = MAX_IN_DIM * MAX_IN_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DIM_W = $clog2(MAX_IN_DIM + 1);
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int DCW   = (DIM_W > 7) ? DIM_W : 7;
  localparam int KCW   = (KW > 5) ? KW : 5;

  logic [6:0] in_height, in_width, out_height, out_width;
  logic [4:0] kernel_height, kernel_width, stride_height, stride_width;

  logic [DIM_W-1:0] ih_c, iw_c;
  logic [6:0]       oh_c, ow_c;
  logic [KW-1:0]    kh_c, kw_c;
  logic [4:0]       sh_c, sw_c;

  logic [AW:0]      load_pos, total;
  logic [5:0]       out_row, out_col;
  logic [DIM_W-1:0] win_r0, win_c0;
  logic [KW-1:0]    win_rn, win_cn, rc, cc;
  logic [AW-1:0]    row_addr, addr;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      acc, rdata, quo;
  logic             pend, div_done, ram_we, last_out;
  logic             out_valid;
  logic [15:0]      average;
  logic             last_of_plane;

  logic signed [POS_W-1:0] rlo, rhi, clo, chi;
  logic [2*DIM_W-1:0]      base_prod;

  always_comb begin
    logic [DCW-1:0] x_h, x_w;
    logic [KCW-1:0] k_h, k_w;
    x_h = DCW'(in_height);
    x_w = DCW'(in_width);
    k_h = KCW'(kernel_height);
    k_w = KCW'(kernel_width);
    ih_c = (x_h == '0) ? DIM_W'(1) :
           (x_h > DCW'(MAX_IN_DIM)) ? DIM_W'(MAX_IN_DIM) : DIM_W'(x_h);
    iw_c = (x_w == '0) ? DIM_W'(1) :
           (x_w > DCW'(MAX_IN_DIM)) ? DIM_W'(MAX_IN_DIM) : DIM_W'(x_w);
    kh_c = (k_h == '0) ? KW'(1) :
           (k_h > KCW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(k_h);
    kw_c = (k_w == '0) ? KW'(1) :
           (k_w > KCW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(k_w);
    oh_c = (out_height == 7'd0) ? 7'd1 : (out_height > OUT_MAX) ? OUT_MAX : out_height;
    ow_c = (out_width == 7'd0) ? 7'd1 : (out_width > OUT_MAX) ? OUT_MAX : out_width;
    sh_c = (stride_height == 5'd0) ? 5'd1 :
           (stride_height > STRIDE_MAX) ? STRIDE_MAX : stride_height;
    sw_c = (stride_width == 5'd0) ? 5'd1 :
           (stride_width > STRIDE_MAX) ? STRIDE_MAX : stride_width;
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height     <= 7'd1;
      in_width      <= 7'd1;
      out_height    <= 7'd1;
      out_width     <= 7'd1;
      kernel_height <= 5'd1;
      kernel_width  <= 5'd1;
      stride_height <= 5'd1;
      stride_width  <= 5'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IN_HEIGHT:     in_height     <= cfg.data;
        CFG_IN_WIDTH:      in_width      <= cfg.data;
        CFG_OUT_HEIGHT:    out_height    <= cfg.data;
        CFG_OUT_WIDTH:     out_width     <= cfg.data;
        CFG_KERNEL_HEIGHT: kernel_height <= cfg.data[4:0];
        CFG_KERNEL_WIDTH:  kernel_width  <= cfg.data[4:0];
        CFG_STRIDE_HEIGHT: stride_height <= cfg.data[4:0];
        CFG_STRIDE_WIDTH:  stride_width  <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // window clipping
  always_comb begin
    rlo = $signed(POS_W'(out_row) * POS_W'(sh_c)) - $signed(POS_W'(PAD_H));
    rhi = rlo + $signed(POS_W'(kh_c));
    if (rlo < 0) rlo = '0;
    if (rhi > $signed(POS_W'(ih_c))) rhi = $signed(POS_W'(ih_c));
    clo = $signed(POS_W'(out_col) * POS_W'(sw_c)) - $signed(POS_W'(PAD_W));
    chi = clo + $signed(POS_W'(kw_c));
    if (clo < 0) clo = '0;
    if (chi > $signed(POS_W'(iw_c))) chi = $signed(POS_W'(iw_c));
  end

  assign total     = (AW + 1)'(ih_c) * (AW + 1)'(iw_c);
  assign ram_we    = cmd.load && (load_pos < total);
  assign base_prod = (2 * DIM_W)'(win_r0) * (2 * DIM_W)'(iw_c);
  assign last_out  = ({1'b0, out_row} == oh_c - 7'd1) && ({1'b0, out_col} == ow_c - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      out_row  <= 6'd0;
      out_col  <= 6'd0;
    end else begin
      if (ram_we) load_pos <= load_pos + 1'b1;
      if (cmd.req) begin
        if ({1'b0, out_row} >= oh_c) out_row <= 6'd0;
        if ({1'b0, out_col} >= ow_c) out_col <= 6'd0;
      end
      if (cmd.out_load) begin
        if (last_out) begin
          out_row  <= 6'd0;
          out_col  <= 6'd0;
          load_pos <= '0;
        end else if ({1'b0, out_col} + 7'd1 >= ow_c) begin
          out_col <= 6'd0;
          out_row <= out_row + 6'd1;
        end else begin
          out_col <= out_col + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      win_r0 <= DIM_W'(rlo);
      win_c0 <= DIM_W'(clo);
      win_rn <= (rhi > rlo) ? KW'(rhi - rlo) : '0;
      win_cn <= (chi > clo) ? KW'(chi - clo) : '0;
    end
    if (cmd.base) begin
      row_addr <= AW'(base_prod) + AW'(win_c0);
      addr     <= AW'(base_prod) + AW'(win_c0);
      rc       <= '0;
      cc       <= '0;
      cnt      <= CNT_W'(win_rn) * CNT_W'(win_cn);
    end else if (cmd.issue) begin
      if (cc == win_cn - 1'b1) begin
        cc       <= '0;
        rc       <= rc + 1'b1;
        row_addr <= row_addr + AW'(iw_c);
        addr     <= row_addr + AW'(iw_c);
      end else begin
        cc   <= cc + 1'b1;
        addr <= addr + 1'b1;
      end
    end
    if (cmd.base) begin
      acc <= 16'd0;
    end else if (pend) begin
      acc <= fp16_add(acc, rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.issue;
    end
  end

  avp_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(load_pos[AW-1:0]),
    .wdata(in_item.pixel),
    .re   (cmd.issue),
    .raddr(addr),
    .rdata(rdata)
  );

  avp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (acc),
    .cnt  (cnt),
    .done (div_done),
    .quo  (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average       <= sts.empty ? 16'd0 : quo;
      last_of_plane <= last_out;
    end
  end

  assign out_item.valid         = out_valid;
  assign out_item.average       = average;
  assign out_item.last_of_plane = last_of_plane;

  assign sts.empty      = (win_rn == '0) || (win_cn == '0);
  assign sts.last_issue = (cc == win_cn - 1'b1) && (rc == win_rn - 1'b1);
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_item.ready;

  a_load_in_plane: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (load_pos < total))
    else $error("plane write past plane size");

  a_add_follows_read: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(cmd.issue))
    else $error("accumulate without a read");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_item.ready))
    else $error("result overwritten before taken");

endmodule

// ===== design/average_pool_2d_fp16.sv =====
// ----------------------------------------------------------------------------
// average_pool_2d_fp16: fp16 2d average pooling, padding excluded from count
// A load (mode 0) stores one pixel in the plane RAM; loads past the plane
// size are dropped. A request (mode 1) reads the clipped window's pixels
// from the plane RAM and sums them one per cycle through a single fp16 adder,
// and the sum then goes through an iterative divider, which skips its
// iterations when the sum is zero, infinite or NaN. An empty window skips
// both and returns +0. There is no clearing pass after reset; the plane RAM
// must be loaded before its entries are read.
// ----------------------------------------------------------------------------
module average_pool_2d_fp16 #(
  parameter int MAX_IN_DIM = 64,
  parameter int MAX_KERNEL = 16,
  parameter int PAD_H      = 0,
  parameter int PAD_W      = 0
) (
  input logic       clk,
  input logic       rst,
  avp_in_if.sink    in_item,
  avp_out_if.source out_item,
  avp_cfg_if.sink   cfg
);

  import avp_pkg::*;

  avp_cmd_t cmd;
  avp_sts_t sts;

  avp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_item.valid),
    .in_mode (in_item.mode),
    .in_ready(in_item.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  avp_dp #(
    .MAX_IN_DIM(MAX_IN_DIM),
    .MAX_KERNEL(MAX_KERNEL),
    .PAD_H     (PAD_H),
    .PAD_W     (PAD_W)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .out_item(out_item),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

// ===== tb/average_pool_2d_fp16_test.sv =====
// ----------------------------------------------------------------------------
// average_pool_2d_fp16_test: self-checking bench for the fp16 average pool
// Loads planes pixel by pixel and requests pooled outputs under many register
// settings. An in-bench fp16 predictor computes each expected average and the
// end-of-plane flag. A monitor compares every result beat in order. Both sides
// insert random idle cycles.
// ----------------------------------------------------------------------------
module average_pool_2d_fp16_test;
  import avp_pkg::*;

  typedef struct {
    logic        mode;
    logic [15:0] pixel;
  } pool_item_t;

  typedef struct {
    logic [15:0] average;
    logic        last;
  } pool_result_t;

  logic clk;
  logic rst;

  avp_in_if  in_ch ();
  avp_out_if out_ch ();
  avp_cfg_if cfg_ch ();

  average_pool_2d_fp16 u_top (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg      (cfg_ch)
  );

  pool_item_t   pending_items[$];
  pool_result_t pooled_expected[$];
  int unsigned  errors;
  int unsigned  item_count;
  bit           calm;

  // predictor state
  logic [15:0] plane_mem[4096];
  bit          plane_written[4096];
  int unsigned load_pos;
  int unsigned row_idx;
  int unsigned col_idx;
  logic [6:0]  reg_val[8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic real half_to_real(logic [15:0] h);
    logic [63:0] s, m, u;
    int          e, ex;
    s = {h[15], 63'd0};
    e = h[14:10];
    m = {54'd0, h[9:0]};
    if (e == 31) begin
      u = s | {1'b0, 11'h7FF, 52'd0};
      if (m != 0) u = u | (64'd1 << 51) | (m << 42);
      return $bitstoreal(u);
    end
    if (e == 0) begin
      if (m == 0) return $bitstoreal(s);
      ex = -14;
      while (!m[10]) begin
        m = m << 1;
        ex--;
      end
      m = m & 64'h3FF;
    end else begin
      ex = e - 15;
    end
    return $bitstoreal(s | (64'(ex + 1023) << 52) | (m << 42));
  endfunction

  function automatic logic [15:0] real_to_half(real d);
    logic [63:0] u, f, sig, mant, rem, hlf;
    logic [15:0] s;
    int          be, ex, lo, sh;
    logic [31:0] outb;
    u  = $realtobits(d);
    s  = {u[63], 15'd0};
    be = u[62:52];
    f  = {12'd0, u[51:0]};
    if (be == 2047) return (f != 0) ? FP16_QNAN : (s | 16'h7C00);
    if (be == 0) return s;
    ex = be - 1023;
    if (ex > 15) return s | 16'h7C00;
    sig = f | (64'd1 << 52);
    lo  = (ex < -14) ? -14 : ex;
    sh  = 42 + (lo - ex);
    if (sh > 54) return s;
    mant = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    hlf  = 64'd1 << (sh - 1);
    if (rem > hlf || (rem == hlf && mant[0])) mant++;
    outb = ((ex < -14) ? 32'd0 : 32'(ex + 14) << 10) + 32'(mant);
    if (outb >= 32'h7C00) return s | 16'h7C00;
    return s | outb[15:0];
  endfunction

  function automatic int unsigned reg_eff(int i);
    int unsigned v, hi;
    v  = (i < 4) ? int'(reg_val[i]) : int'(reg_val[i] & 7'h1F);
    hi = (i < 4) ? 64 : 16;
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clip_range(int unsigned idx, int unsigned step, int pad,
                                     int unsigned size, int unsigned lim,
                                     output int unsigned first, output int unsigned cnt);
    int lo, hi;
    lo = int'(idx * step) - pad;
    hi = lo + int'(size);
    if (lo < 0) lo = 0;
    if (hi > int'(lim)) hi = int'(lim);
    first = lo;
    cnt   = (hi > lo) ? hi - lo : 0;
  endfunction

  // returns 0 without stepping to the next output when the window touches unwritten entries
  function automatic bit predict_pool(output pool_result_t res);
    int unsigned ih, iw, oh, ow, r0, rn, c0, cn, a;
    logic [15:0] acc;
    bit          last;
    ih = reg_eff(CFG_IN_HEIGHT);
    iw = reg_eff(CFG_IN_WIDTH);
    oh = reg_eff(CFG_OUT_HEIGHT);
    ow = reg_eff(CFG_OUT_WIDTH);
    if (row_idx >= oh) row_idx = 0;
    if (col_idx >= ow) col_idx = 0;
    clip_range(row_idx, reg_eff(CFG_STRIDE_HEIGHT), 0, reg_eff(CFG_KERNEL_HEIGHT), ih, r0, rn);
    clip_range(col_idx, reg_eff(CFG_STRIDE_WIDTH), 0, reg_eff(CFG_KERNEL_WIDTH), iw, c0, cn);
    for (int r = 0; r < rn; r++)
      for (int c = 0; c < cn; c++) begin
        a = ((r0 + r) * iw + c0 + c) % 4096;
        if (!plane_written[a]) return 0;
      end
    acc = 16'h0000;
    if (rn != 0 && cn != 0) begin
      for (int r = 0; r < rn; r++)
        for (int c = 0; c < cn; c++) begin
          a   = ((r0 + r) * iw + c0 + c) % 4096;
          acc = real_to_half(half_to_real(acc) + half_to_real(plane_mem[a]));
        end
      acc = real_to_half(half_to_real(acc) /
                         half_to_real(real_to_half(real'(rn * cn))));
    end
    last        = (row_idx == oh - 1) && (col_idx == ow - 1);
    res.average = acc;
    res.last    = last;
    if (last) begin
      row_idx  = 0;
      col_idx  = 0;
      load_pos = 0;
    end else if (col_idx + 1 >= ow) begin
      col_idx = 0;
      row_idx++;
    end else begin
      col_idx++;
    end
    return 1;
  endfunction

  function automatic logic [15:0] rand_pixel();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
    if (k < 75) return 16'($urandom);
    if (k < 85) return {1'($urandom), 5'd0, ($urandom_range(0, 1) != 0) ? 10'($urandom) : 10'd0};
    if (k < 90) return {1'($urandom), 5'h1F, ($urandom_range(0, 1) != 0) ? 10'($urandom) : 10'd0};
    return {1'($urandom), 5'($urandom_range(28, 30)), 10'($urandom)};
  endfunction

  function automatic void push_load(logic [15:0] pix);
    pool_item_t it;
    it.mode  = 1'b0;
    it.pixel = pix;
    pending_items.push_back(it);
    if (load_pos < reg_eff(CFG_IN_HEIGHT) * reg_eff(CFG_IN_WIDTH)) begin
      plane_mem[load_pos]     = pix;
      plane_written[load_pos] = 1'b1;
      load_pos++;
      item_count++;
    end
  endfunction

  function automatic void push_request();
    pool_item_t   it;
    pool_result_t res;
    if (predict_pool(res)) begin
      it.mode  = 1'b1;
      it.pixel = 16'($urandom);
      pending_items.push_back(it);
      pooled_expected.push_back(res);
      item_count++;
    end else begin
      push_load(rand_pixel());
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [6:0] v);
    reg_val[idx] = v;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || pooled_expected.size() != 0 || in_ch.valid);
    repeat (400) @(posedge clk);
  endtask

  task automatic run_planes(int unsigned planes, int unsigned extra_max);
    int unsigned n, reqs;
    for (int p = 0; p < planes; p++) begin
      n = reg_eff(CFG_IN_HEIGHT) * reg_eff(CFG_IN_WIDTH) + $urandom_range(0, extra_max);
      for (int i = 0; i < n; i++) push_load(rand_pixel());
      reqs = reg_eff(CFG_OUT_HEIGHT) * reg_eff(CFG_OUT_WIDTH);
      if ($urandom_range(0, 9) == 0) reqs = $urandom_range(1, reqs + 3);
      for (int i = 0; i < reqs; i++) push_request();
    end
  endtask

  function automatic logic [6:0] pick_reg(int unsigned lo_r, int unsigned hi_r, int unsigned top);
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return 7'd0;
    if (k == 1) return 7'($urandom_range(top + 1, 127));
    return 7'($urandom_range(lo_r, hi_r));
  endfunction

  // driver
  int unsigned in_gap;
  always @(posedge clk) begin
    logic       nv;
    pool_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) nv = 1'b0;
      if (!nv) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          in_ch.mode  <= it.mode;
          in_ch.pixel <= it.pixel;
          nv = 1'b1;
          in_gap = calm ? 0 : $urandom_range(0, 4);
        end
      end
      in_ch.valid <= nv;
    end
  end

  // monitor
  int unsigned out_stall;
  always @(posedge clk) begin
    pool_result_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pooled_expected.size() == 0) begin
          $display("%0t: unexpected beat average=%h last=%b", $time,
                   out_ch.average, out_ch.last_of_plane);
          errors++;
        end else begin
          e = pooled_expected.pop_front();
          if (out_ch.average !== e.average) begin
            $display("%0t: average expected %h actual %h", $time, e.average, out_ch.average);
            errors++;
          end
          if (out_ch.last_of_plane !== e.last) begin
            $display("%0t: last_of_plane expected %b actual %b", $time, e.last,
                     out_ch.last_of_plane);
            errors++;
          end
        end
        out_stall = calm ? 0 : $urandom_range(0, 4);
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("average_pool_2d_fp16_test: errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned phase;
    errors       = 0;
    item_count   = 0;
    calm         = 1'b0;
    load_pos     = 0;
    row_idx      = 0;
    col_idx      = 0;
    for (int i = 0; i < 8; i++) reg_val[i] = 7'd1;
    for (int i = 0; i < 4096; i++) begin
      plane_mem[i]     = 16'h0000;
      plane_written[i] = 1'b0;
    end
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.mode   = 1'b0;
    in_ch.pixel  = 16'h0000;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_IN_HEIGHT;
    cfg_ch.data  = 7'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 1x1 plane, single output
    push_load(16'h3C00);
    push_request();
    wait_drained();

    // overflow, negative infinity, nan, subnormal, empty bottom rows
    write_reg(CFG_IN_HEIGHT, 7'd2);
    write_reg(CFG_IN_WIDTH, 7'd3);
    write_reg(CFG_OUT_HEIGHT, 7'd3);
    write_reg(CFG_OUT_WIDTH, 7'd2);
    write_reg(CFG_KERNEL_HEIGHT, 7'd2);
    write_reg(CFG_KERNEL_WIDTH, 7'd2);
    write_reg(CFG_STRIDE_HEIGHT, 7'd2);
    write_reg(CFG_STRIDE_WIDTH, 7'd1);
    push_load(16'h7BFF);
    push_load(16'h7BFF);
    push_load(16'hFC00);
    push_load(16'h7BFF);
    push_load(16'h7E01);
    push_load(16'h0001);
    push_load(16'hFFFF);
    for (int i = 0; i < 6; i++) push_request();
    wait_drained();

    // full-height plane, largest window and height stride, out-of-range writes
    write_reg(CFG_IN_HEIGHT, 7'd127);
    write_reg(CFG_IN_WIDTH, 7'd16);
    write_reg(CFG_OUT_HEIGHT, 7'd4);
    write_reg(CFG_OUT_WIDTH, 7'd5);
    write_reg(CFG_KERNEL_HEIGHT, 7'h1F);
    write_reg(CFG_KERNEL_WIDTH, 7'd16);
    write_reg(CFG_STRIDE_HEIGHT, 7'h30);
    write_reg(CFG_STRIDE_WIDTH, 7'd4);
    run_planes(1, 0);
    wait_drained();

    // tall output, narrow plane, mostly empty windows
    write_reg(CFG_IN_HEIGHT, 7'd3);
    write_reg(CFG_IN_WIDTH, 7'd0);
    write_reg(CFG_OUT_HEIGHT, 7'd127);
    write_reg(CFG_OUT_WIDTH, 7'd1);
    write_reg(CFG_KERNEL_HEIGHT, 7'd0);
    write_reg(CFG_STRIDE_HEIGHT, 7'd16);
    run_planes(1, 2);
    wait_drained();

    phase = 0;
    while (item_count < 1850) begin
      calm = ($urandom_range(0, 4) == 0);
      write_reg(CFG_IN_HEIGHT, 7'($urandom_range(1, 8)));
      write_reg(CFG_IN_WIDTH, 7'($urandom_range(1, 8)));
      write_reg(CFG_OUT_HEIGHT, 7'($urandom_range(1, 6)));
      write_reg(CFG_OUT_WIDTH, 7'($urandom_range(1, 6)));
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_KERNEL_HEIGHT, pick_reg(1, 16, 31));
        write_reg(CFG_KERNEL_WIDTH, pick_reg(1, 16, 31));
        write_reg(CFG_STRIDE_HEIGHT, pick_reg(1, 16, 31));
        write_reg(CFG_STRIDE_WIDTH, pick_reg(1, 16, 31));
      end else begin
        write_reg(CFG_KERNEL_HEIGHT, pick_reg(1, 5, 31));
        write_reg(CFG_KERNEL_WIDTH, pick_reg(1, 5, 31));
        write_reg(CFG_STRIDE_HEIGHT, pick_reg(1, 4, 31));
        write_reg(CFG_STRIDE_WIDTH, pick_reg(1, 4, 31));
      end
      run_planes($urandom_range(1, 3), ($urandom_range(0, 2) == 0) ? 3 : 0);
      wait_drained();
      phase++;
    end

    if (errors == 0) begin
      $display("average_pool_2d_fp16_test: clean");
    end else begin
      $display("average_pool_2d_fp16_test: errors");
    end
    $finish;
  end

endmodule
